/* src/stok_pkg.sv */
// Shared types, token codes and lookup functions for the source tokenizer.
// No dependencies.
`default_nettype none
package stok_pkg;

  typedef enum logic [5:0] {
    K_LPAREN, K_RPAREN, K_LBRACE, K_RBRACE, K_LBRACK, K_RBRACK,
    K_AMP_EQ, K_AMP, K_TILDE, K_PIPE_EQ, K_PIPE, K_CARET_EQ, K_CARET,
    K_COLON, K_SEMI, K_DOT2_EQ, K_DOT2, K_DOT, K_COMMA, K_EQ2, K_FAT_ARROW,
    K_EQ, K_BANG_EQ, K_BANG, K_PLUS_EQ, K_PLUS, K_MINUS_EQ, K_ARROW, K_MINUS,
    K_STAR_EQ, K_STAR, K_SLASH_EQ, K_SLASH, K_PCT_EQ, K_PCT, K_GT_EQ,
    K_SHR_EQ, K_SHR, K_GT, K_LT_EQ, K_SHL_EQ, K_SHL, K_LT,
    K_EOF, K_IDENT, K_INT, K_FLOAT, K_ILLEGAL
  } kind_t;

  typedef enum logic [10:0] {
    M_BOM        = 11'b000_0000_0001,
    M_IDLE       = 11'b000_0000_0010,
    M_IDENT      = 11'b000_0000_0100,
    M_INT        = 11'b000_0000_1000,
    M_INT_DOT    = 11'b000_0001_0000,
    M_FRAC       = 11'b000_0010_0000,
    M_OP         = 11'b000_0100_0000,
    M_LINE       = 11'b000_1000_0000,
    M_BLOCK      = 11'b001_0000_0000,
    M_BLOCK_STAR = 11'b010_0000_0000,
    M_DRAIN      = 11'b100_0000_0000
  } mode_t;

  typedef enum logic [2:0] {X_NONE, X_DONE, X_MORE, X_BLOCK, X_LINE} xact_t;

  typedef struct packed {
    xact_t act;
    kind_t kind;
  } ext_t;

  typedef struct packed {
    kind_t       kind;
    logic [19:0] first;
    logic [19:0] last;
  } tok_t;

  typedef struct packed {
    tok_t [2:0] tok;
    logic [1:0] cnt;
  } bundle_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw = $clog2(QDepth);
  localparam logic [20:0] PosMax = 21'h10_0000;

  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChRpar  = 8'h29;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChNl    = 8'h0A;

  function automatic logic [7:0] bom_byte(logic [1:0] i);
    case (i)
      2'd0:    return 8'hEF;
      2'd1:    return 8'hBB;
      default: return 8'hBF;
    endcase
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic [19:0] clamp(logic [20:0] p);
    return p[20] ? 20'hF_FFFF : p[19:0];
  endfunction

  function automatic ext_t mk(xact_t a, kind_t k);
    ext_t e;
    e.act = a;
    e.kind = k;
    return e;
  endfunction

  function automatic ext_t extend(kind_t k, logic [7:0] b);
    ext_t e;
    e = mk(X_NONE, k);
    case (k)
      K_LPAREN: if (b == ChStar) e = mk(X_BLOCK, k);
      K_AMP:    if (b == ChEq) e = mk(X_DONE, K_AMP_EQ);
      K_PIPE:   if (b == ChEq) e = mk(X_DONE, K_PIPE_EQ);
      K_CARET:  if (b == ChEq) e = mk(X_DONE, K_CARET_EQ);
      K_DOT:    if (b == ".") e = mk(X_MORE, K_DOT2);
      K_DOT2:   if (b == ChEq) e = mk(X_DONE, K_DOT2_EQ);
      K_EQ: begin
        if (b == ChEq) e = mk(X_DONE, K_EQ2);
        else if (b == ">") e = mk(X_DONE, K_FAT_ARROW);
      end
      K_BANG:   if (b == ChEq) e = mk(X_DONE, K_BANG_EQ);
      K_PLUS:   if (b == ChEq) e = mk(X_DONE, K_PLUS_EQ);
      K_MINUS: begin
        if (b == ChEq) e = mk(X_DONE, K_MINUS_EQ);
        else if (b == ">") e = mk(X_DONE, K_ARROW);
      end
      K_STAR:   if (b == ChEq) e = mk(X_DONE, K_STAR_EQ);
      K_SLASH: begin
        if (b == ChEq) e = mk(X_DONE, K_SLASH_EQ);
        else if (b == "/") e = mk(X_LINE, k);
      end
      K_PCT:    if (b == ChEq) e = mk(X_DONE, K_PCT_EQ);
      K_GT: begin
        if (b == ChEq) e = mk(X_DONE, K_GT_EQ);
        else if (b == ">") e = mk(X_MORE, K_SHR);
      end
      K_SHR:    if (b == ChEq) e = mk(X_DONE, K_SHR_EQ);
      K_LT: begin
        if (b == ChEq) e = mk(X_DONE, K_LT_EQ);
        else if (b == "<") e = mk(X_MORE, K_SHL);
      end
      K_SHL:    if (b == ChEq) e = mk(X_DONE, K_SHL_EQ);
      default:  e = mk(X_NONE, k);
    endcase
    return e;
  endfunction

  function automatic bundle_t add_tok(bundle_t bi, kind_t k, logic [19:0] f,
                                      logic [19:0] l);
    bundle_t r;
    r = bi;
    if (bi.cnt != 2'd3) begin
      r.tok[bi.cnt].kind = k;
      r.tok[bi.cnt].first = f;
      r.tok[bi.cnt].last = l;
      r.cnt = bi.cnt + 2'd1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/source_tokenizer.sv */
// Top level of the source tokenizer: scanner, group queue and output stage.
// Depends on stok_pkg, stok_front, stok_queue, stok_back.
//
// Takes one source byte per cycle while full is low; each byte yields zero to
// three tokens, which come out one per pop, oldest first, run_last marking the
// final token of a byte. A four-entry queue of token groups lets the byte side
// keep running while the result side stalls, so a byte that makes several
// tokens costs extra output cycles only, not input cycles.
`default_nettype none
module source_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_source_byte,
  input  wire logic        in_end_of_source,
  output logic             empty,
  input  wire logic        pop,
  output logic [5:0]       out_token_kind,
  output logic [19:0]      out_lexeme_first,
  output logic [19:0]      out_lexeme_final,
  output logic             out_run_last
);
  import stok_pkg::*;

  bundle_t grp, q_data;
  logic    grp_push, q_valid, q_rd, accept;

  assign accept = push && !full;

  stok_front u_front (
    .clk, .rst_n, .accept,
    .src_byte(in_source_byte), .src_end(in_end_of_source),
    .grp, .grp_push
  );

  stok_queue u_queue (
    .clk, .rst_n, .wr_en(grp_push), .wdata(grp), .full,
    .rd_valid(q_valid), .rd_en(q_rd), .rdata(q_data)
  );

  stok_back u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_rd, .empty, .pop,
    .token_kind(out_token_kind), .first(out_lexeme_first),
    .last(out_lexeme_final), .run_last(out_run_last)
  );

endmodule
`default_nettype wire

/* src/stok_front.sv */
// Scanner front end: accepts source bytes and forms the token group of each byte.
// Depends on stok_pkg.
`default_nettype none
module stok_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [7:0]       src_byte,
  input  wire logic             src_end,
  output stok_pkg::bundle_t     grp,
  output logic                  grp_push
);
  import stok_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  bp_r, bp_nxt;
  logic [20:0] pos_r, pos_nxt;
  logic [19:0] ls_r, ls_nxt;
  kind_t       pk_r, pk_nxt;

  function automatic logic [20:0] adv(logic [20:0] p);
    return (p < PosMax) ? p + 21'd1 : p;
  endfunction

  function automatic bundle_t fin(bundle_t bi, mode_t m, logic [19:0] ls, kind_t pk,
                                  logic [20:0] p);
    bundle_t r;
    logic [19:0] pm1;
    pm1 = clamp(p - 21'd1);
    r = bi;
    case (m)
      M_IDENT:      r = add_tok(r, K_IDENT, ls, pm1);
      M_INT:        r = add_tok(r, K_INT, ls, pm1);
      M_INT_DOT:    r = add_tok(r, K_ILLEGAL, ls, pm1);
      M_FRAC:       r = add_tok(r, K_FLOAT, ls, pm1);
      M_OP:         r = add_tok(r, pk, ls, pm1);
      M_BLOCK:      r = add_tok(r, K_ILLEGAL, ls, pm1);
      M_BLOCK_STAR: r = add_tok(r, K_ILLEGAL, ls, pm1);
      default:      r = bi;
    endcase
    return add_tok(r, K_EOF, clamp(p), clamp(p));
  endfunction

  bundle_t     bun;
  logic        go, disp, emit1, restart;
  logic [19:0] cur, pm1;
  ext_t        x;
  mode_t       dmode;
  kind_t       dkind;

  always_comb begin
    mode_nxt = mode_r;
    bp_nxt = bp_r;
    pos_nxt = pos_r;
    ls_nxt = ls_r;
    pk_nxt = pk_r;
    bun = '0;
    go = 1'b0;
    disp = 1'b0;
    emit1 = 1'b0;
    restart = 1'b0;
    dmode = M_IDLE;
    dkind = K_ILLEGAL;
    cur = clamp(pos_r);
    pm1 = clamp(pos_r - 21'd1);
    x = extend(pk_r, src_byte);
    if (mode_r == M_DRAIN) begin
      if (src_end) begin
        mode_nxt = M_BOM;
        restart = 1'b1;
      end
    end else begin
      go = 1'b1;
      if (mode_r == M_BOM) begin
        if (bp_r != 2'd3 && src_byte == bom_byte(bp_r)) begin
          go = 1'b0;
          bp_nxt = bp_r + 2'd1;
          pos_nxt = adv(pos_r);
          if (bp_nxt == 2'd3) begin
            mode_nxt = M_IDLE;
            bp_nxt = 2'd0;
          end
          if (src_end) begin
            bun = add_tok(bun, K_EOF, clamp(pos_nxt), clamp(pos_nxt));
            mode_nxt = M_BOM;
            restart = 1'b1;
          end
        end else begin
          if (bp_r != 2'd0) bun = add_tok(bun, K_ILLEGAL, '0, {18'd0, bp_r - 2'd1});
          bp_nxt = 2'd0;
          mode_nxt = M_IDLE;
        end
      end
      if (go) begin
        if (src_byte == 8'd0) begin
          bun = fin(bun, mode_nxt, ls_r, pk_r, pos_r);
          mode_nxt = src_end ? M_BOM : M_DRAIN;
          restart = src_end;
        end else begin
          case (mode_nxt)
            M_IDENT: if (!(is_alpha(src_byte) || is_digit(src_byte) ||
                           src_byte == ChUnder)) begin
              bun = add_tok(bun, K_IDENT, ls_r, pm1);
              disp = 1'b1;
            end
            M_INT: begin
              if (src_byte == ".") mode_nxt = M_INT_DOT;
              else if (!is_digit(src_byte)) begin
                bun = add_tok(bun, K_INT, ls_r, pm1);
                disp = 1'b1;
              end
            end
            M_INT_DOT: begin
              if (is_digit(src_byte)) mode_nxt = M_FRAC;
              else begin
                bun = add_tok(bun, K_ILLEGAL, ls_r, cur);
                mode_nxt = M_IDLE;
              end
            end
            M_FRAC: if (!is_digit(src_byte)) begin
              bun = add_tok(bun, K_FLOAT, ls_r, pm1);
              disp = 1'b1;
            end
            M_LINE: if (src_byte == ChNl) mode_nxt = M_IDLE;
            M_BLOCK: if (src_byte == ChStar) mode_nxt = M_BLOCK_STAR;
            M_BLOCK_STAR: begin
              if (src_byte == ChRpar) mode_nxt = M_IDLE;
              else if (src_byte != ChStar) mode_nxt = M_BLOCK;
            end
            M_OP: begin
              case (x.act)
                X_BLOCK: mode_nxt = M_BLOCK;
                X_LINE:  mode_nxt = M_LINE;
                X_MORE:  pk_nxt = x.kind;
                X_DONE: begin
                  bun = add_tok(bun, x.kind, ls_r, cur);
                  mode_nxt = M_IDLE;
                end
                default: begin
                  bun = add_tok(bun, pk_r, ls_r, pm1);
                  disp = 1'b1;
                end
              endcase
            end
            default: disp = 1'b1;
          endcase
          if (disp) begin
            case (src_byte)
              " ", 8'h0A, 8'h09, 8'h0D: dmode = M_IDLE;
              "(": begin dmode = M_OP; dkind = K_LPAREN; end
              ")": begin emit1 = 1'b1; dkind = K_RPAREN; end
              "{": begin emit1 = 1'b1; dkind = K_LBRACE; end
              "}": begin emit1 = 1'b1; dkind = K_RBRACE; end
              "[": begin emit1 = 1'b1; dkind = K_LBRACK; end
              "]": begin emit1 = 1'b1; dkind = K_RBRACK; end
              "&": begin dmode = M_OP; dkind = K_AMP; end
              "~": begin emit1 = 1'b1; dkind = K_TILDE; end
              "|": begin dmode = M_OP; dkind = K_PIPE; end
              "^": begin dmode = M_OP; dkind = K_CARET; end
              ":": begin emit1 = 1'b1; dkind = K_COLON; end
              ";": begin emit1 = 1'b1; dkind = K_SEMI; end
              ".": begin dmode = M_OP; dkind = K_DOT; end
              ",": begin emit1 = 1'b1; dkind = K_COMMA; end
              "=": begin dmode = M_OP; dkind = K_EQ; end
              "!": begin dmode = M_OP; dkind = K_BANG; end
              "+": begin dmode = M_OP; dkind = K_PLUS; end
              "-": begin dmode = M_OP; dkind = K_MINUS; end
              "*": begin dmode = M_OP; dkind = K_STAR; end
              "/": begin dmode = M_OP; dkind = K_SLASH; end
              "%": begin dmode = M_OP; dkind = K_PCT; end
              ">": begin dmode = M_OP; dkind = K_GT; end
              "<": begin dmode = M_OP; dkind = K_LT; end
              default: begin
                if (is_alpha(src_byte) || src_byte == ChUnder) dmode = M_IDENT;
                else if (is_digit(src_byte)) dmode = M_INT;
                else emit1 = 1'b1;
              end
            endcase
            mode_nxt = dmode;
            ls_nxt = cur;
            if (dmode == M_OP) pk_nxt = dkind;
            if (emit1) bun = add_tok(bun, dkind, cur, cur);
          end
          pos_nxt = adv(pos_r);
          if (src_end) begin
            bun = fin(bun, mode_nxt, ls_nxt, pk_nxt, pos_nxt);
            mode_nxt = M_BOM;
            restart = 1'b1;
          end
        end
      end
    end
    if (restart) begin
      bp_nxt = 2'd0;
      pos_nxt = '0;
      ls_nxt = '0;
      pk_nxt = K_LPAREN;
    end
  end

  assign grp = bun;
  assign grp_push = accept && (bun.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_BOM;
      bp_r <= 2'd0;
      pos_r <= '0;
      ls_r <= '0;
      pk_r <= K_LPAREN;
    end else if (accept) begin
      mode_r <= mode_nxt;
      bp_r <= bp_nxt;
      pos_r <= pos_nxt;
      ls_r <= ls_nxt;
      pk_r <= pk_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/stok_queue.sv */
// Short queue of token groups between the scanner and the output stage.
// Depends on stok_pkg.
`default_nettype none
module stok_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_en,
  input  stok_pkg::bundle_t wdata,
  output logic              full,
  output logic              rd_valid,
  input  wire logic         rd_en,
  output stok_pkg::bundle_t rdata
);
  import stok_pkg::*;

  bundle_t          mem_r [QDepth];
  logic [QAw-1:0]   wp_r, rp_r;
  logic [QAw:0]     cnt_r, cnt_nxt;

  assign full = cnt_r == QAw'(0) + (QAw+1)'(QDepth);
  assign rd_valid = cnt_r != '0;
  assign rdata = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !(rd_en && rd_valid)) cnt_nxt = cnt_r + 1'b1;
    else if (!wr_en && rd_en && rd_valid) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en && rd_valid) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full || rd_en) else $error("token queue overflow");
  a_nonempty_group: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> wdata.cnt != 2'd0) else $error("empty token group queued");
`endif

endmodule
`default_nettype wire

/* src/stok_back.sv */
// Output stage: hands out the tokens of each group one transfer at a time.
// Depends on stok_pkg.
`default_nettype none
module stok_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_valid,
  input  stok_pkg::bundle_t q_data,
  output logic              q_rd,
  output logic              empty,
  input  wire logic         pop,
  output logic [5:0]        token_kind,
  output logic [19:0]       first,
  output logic [19:0]       last,
  output logic              run_last
);
  import stok_pkg::*;

  bundle_t    grp_r;
  logic [1:0] idx_r;
  logic       valid_r;
  logic       at_end, take;

  assign at_end = idx_r == grp_r.cnt - 2'd1;
  assign take = pop && valid_r;
  assign q_rd = q_valid && (!valid_r || (take && at_end));

  assign empty = !valid_r;
  assign token_kind = grp_r.tok[idx_r].kind;
  assign first = grp_r.tok[idx_r].first;
  assign last = grp_r.tok[idx_r].last;
  assign run_last = at_end;

  always_ff @(posedge clk) begin
    if (q_rd) grp_r <= q_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r <= 2'd0;
    end else if (q_rd) begin
      valid_r <= 1'b1;
      idx_r <= 2'd0;
    end else if (take) begin
      if (at_end) valid_r <= 1'b0;
      else idx_r <= idx_r + 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> idx_r < grp_r.cnt) else $error("token index past group");
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    take && !at_end |=> valid_r && idx_r == $past(idx_r) + 2'd1)
    else $error("token index did not advance");
  a_refill: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r && q_valid |=> valid_r && idx_r == 2'd0)
    else $error("output stage not refilled");
`endif

endmodule
`default_nettype wire

/* dv/tb_source_tokenizer.sv */
// Testbench for source_tokenizer: streams source bytes through the push side and
// checks every popped token against an in-bench scanner model. Depends on stok_pkg.
module tb_source_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;
  import stok_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
  } src_byte_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [19:0] first;
    logic [19:0] fin;
    logic        last;
  } token_t;

  localparam logic [3:0] S_BOM = 4'd0, S_IDLE = 4'd1, S_IDENT = 4'd2, S_INT = 4'd3,
    S_INT_DOT = 4'd4, S_FRAC = 4'd5, S_OP = 4'd6, S_LINE = 4'd7, S_BLOCK = 4'd8,
    S_BLOCK_STAR = 4'd9, S_DRAIN = 4'd10;
  localparam int Limit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [7:0] in_source_byte = '0;
  logic in_end_of_source = 1'b0;
  logic full, empty, out_run_last;
  logic [5:0] out_token_kind;
  logic [19:0] out_lexeme_first, out_lexeme_final;

  source_tokenizer DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  src_byte_t pending_bytes[$];
  token_t expected_tokens[$];
  token_t step_toks[$];
  int mismatches = 0;
  int cycles = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;
  logic took = 1'b0;

  // scanner model state
  logic [3:0]  sc_mode;
  logic [1:0]  sc_bom;
  logic [20:0] sc_pos;
  logic [19:0] sc_start;
  logic [5:0]  sc_pend;

  function automatic logic [19:0] sat(logic [20:0] p);
    return p > 21'h0F_FFFF ? 20'hF_FFFF : p[19:0];
  endfunction

  function automatic bit dig(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit alph(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  task automatic add_token(logic [5:0] k, logic [20:0] f, logic [20:0] l);
    token_t t;
    if (step_toks.size() < 3) begin
      t.kind = k; t.first = sat(f); t.fin = sat(l); t.last = 1'b0;
      step_toks.push_back(t);
    end
  endtask

  task automatic scanner_reset();
    sc_mode = S_BOM; sc_bom = 0; sc_pos = 0; sc_start = 0; sc_pend = 0;
  endtask

  task automatic open_op(logic [5:0] k, logic [20:0] p);
    sc_mode = S_OP; sc_pend = k; sc_start = sat(p);
  endtask

  task automatic start_tok(logic [7:0] b, logic [20:0] p);
    sc_mode = S_IDLE;
    case (b)
      " ", 8'h0A, 8'h09, 8'h0D: ;
      "(": open_op(K_LPAREN, p);
      ")": add_token(K_RPAREN, p, p);
      "{": add_token(K_LBRACE, p, p);
      "}": add_token(K_RBRACE, p, p);
      "[": add_token(K_LBRACK, p, p);
      "]": add_token(K_RBRACK, p, p);
      "&": open_op(K_AMP, p);
      "~": add_token(K_TILDE, p, p);
      "|": open_op(K_PIPE, p);
      "^": open_op(K_CARET, p);
      ":": add_token(K_COLON, p, p);
      ";": add_token(K_SEMI, p, p);
      ".": open_op(K_DOT, p);
      ",": add_token(K_COMMA, p, p);
      "=": open_op(K_EQ, p);
      "!": open_op(K_BANG, p);
      "+": open_op(K_PLUS, p);
      "-": open_op(K_MINUS, p);
      "*": open_op(K_STAR, p);
      "/": open_op(K_SLASH, p);
      "%": open_op(K_PCT, p);
      ">": open_op(K_GT, p);
      "<": open_op(K_LT, p);
      default: begin
        if (alph(b)) begin
          sc_mode = S_IDENT; sc_start = sat(p);
        end else if (dig(b)) begin
          sc_mode = S_INT; sc_start = sat(p);
        end else add_token(K_ILLEGAL, p, p);
      end
    endcase
  endtask

  // returns: 0 none, 1 done (kind in nk), 2 more (nk), 3 block, 4 line
  function automatic int op_grow(logic [5:0] k, logic [7:0] b, output logic [5:0] nk);
    nk = k;
    case (k)
      K_LPAREN: if (b == "*") return 3;
      K_AMP:    if (b == "=") begin nk = K_AMP_EQ; return 1; end
      K_PIPE:   if (b == "=") begin nk = K_PIPE_EQ; return 1; end
      K_CARET:  if (b == "=") begin nk = K_CARET_EQ; return 1; end
      K_DOT:    if (b == ".") begin nk = K_DOT2; return 2; end
      K_DOT2:   if (b == "=") begin nk = K_DOT2_EQ; return 1; end
      K_EQ: begin
        if (b == "=") begin nk = K_EQ2; return 1; end
        if (b == ">") begin nk = K_FAT_ARROW; return 1; end
      end
      K_BANG:   if (b == "=") begin nk = K_BANG_EQ; return 1; end
      K_PLUS:   if (b == "=") begin nk = K_PLUS_EQ; return 1; end
      K_MINUS: begin
        if (b == "=") begin nk = K_MINUS_EQ; return 1; end
        if (b == ">") begin nk = K_ARROW; return 1; end
      end
      K_STAR:   if (b == "=") begin nk = K_STAR_EQ; return 1; end
      K_SLASH: begin
        if (b == "=") begin nk = K_SLASH_EQ; return 1; end
        if (b == "/") return 4;
      end
      K_PCT:    if (b == "=") begin nk = K_PCT_EQ; return 1; end
      K_GT: begin
        if (b == "=") begin nk = K_GT_EQ; return 1; end
        if (b == ">") begin nk = K_SHR; return 2; end
      end
      K_SHR:    if (b == "=") begin nk = K_SHR_EQ; return 1; end
      K_LT: begin
        if (b == "=") begin nk = K_LT_EQ; return 1; end
        if (b == "<") begin nk = K_SHL; return 2; end
      end
      K_SHL:    if (b == "=") begin nk = K_SHL_EQ; return 1; end
      default: ;
    endcase
    return 0;
  endfunction

  task automatic scan_byte(logic [7:0] b, logic [20:0] p);
    logic [5:0] nk;
    int x;
    case (sc_mode)
      S_IDENT: if (!(alph(b) || dig(b))) begin
        add_token(K_IDENT, sc_start, p - 1); start_tok(b, p);
      end
      S_INT: if (b == ".") sc_mode = S_INT_DOT;
      else if (!dig(b)) begin
        add_token(K_INT, sc_start, p - 1); start_tok(b, p);
      end
      S_INT_DOT: if (dig(b)) sc_mode = S_FRAC;
      else begin
        add_token(K_ILLEGAL, sc_start, p); sc_mode = S_IDLE;
      end
      S_FRAC: if (!dig(b)) begin
        add_token(K_FLOAT, sc_start, p - 1); start_tok(b, p);
      end
      S_LINE: if (b == 8'h0A) sc_mode = S_IDLE;
      S_BLOCK: if (b == "*") sc_mode = S_BLOCK_STAR;
      S_BLOCK_STAR: if (b == ")") sc_mode = S_IDLE;
      else if (b != "*") sc_mode = S_BLOCK;
      S_OP: begin
        x = op_grow(sc_pend, b, nk);
        case (x)
          3: sc_mode = S_BLOCK;
          4: sc_mode = S_LINE;
          2: sc_pend = nk;
          1: begin add_token(nk, sc_start, p); sc_mode = S_IDLE; end
          default: begin add_token(sc_pend, sc_start, p - 1); start_tok(b, p); end
        endcase
      end
      default: start_tok(b, p);
    endcase
  endtask

  task automatic close_source(logic [20:0] p);
    case (sc_mode)
      S_IDENT: add_token(K_IDENT, sc_start, p - 1);
      S_INT: add_token(K_INT, sc_start, p - 1);
      S_INT_DOT: add_token(K_ILLEGAL, sc_start, p - 1);
      S_FRAC: add_token(K_FLOAT, sc_start, p - 1);
      S_OP: add_token(sc_pend, sc_start, p - 1);
      S_BLOCK, S_BLOCK_STAR: add_token(K_ILLEGAL, sc_start, p - 1);
      default: ;
    endcase
    add_token(K_EOF, p, p);
  endtask

  task automatic predict_tokens(logic [7:0] b, logic eos);
    logic [7:0] bb;
    bit bom_hit;
    bom_hit = 1'b0;
    step_toks.delete();
    if (sc_mode == S_DRAIN) begin
      if (eos) scanner_reset();
      return;
    end
    if (sc_mode == S_BOM) begin
      bb = sc_bom == 0 ? 8'hEF : (sc_bom == 1 ? 8'hBB : 8'hBF);
      if (b == bb) begin
        bom_hit = 1'b1;
        sc_bom = sc_bom + 1;
        if (sc_pos < 21'h10_0000) sc_pos = sc_pos + 1;
        if (sc_bom == 3) begin sc_mode = S_IDLE; sc_bom = 0; end
        if (eos) begin add_token(K_EOF, sc_pos, sc_pos); scanner_reset(); end
      end else begin
        if (sc_bom > 0) add_token(K_ILLEGAL, 0, sc_bom - 1);
        sc_bom = 0; sc_mode = S_IDLE;
      end
    end
    if (!bom_hit) begin
      if (b == 8'h00) begin
        close_source(sc_pos);
        if (eos) scanner_reset(); else sc_mode = S_DRAIN;
      end else begin
        scan_byte(b, sc_pos);
        if (sc_pos < 21'h10_0000) sc_pos = sc_pos + 1;
        if (eos) begin close_source(sc_pos); scanner_reset(); end
      end
    end
    if (step_toks.size() > 0) step_toks[$].last = 1'b1;
    foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
  endtask

  task automatic add_text(string s, bit eos_at_end);
    src_byte_t e;
    for (int i = 0; i < s.len(); i++) begin
      e.b = s[i]; e.eos = eos_at_end && i == s.len() - 1;
      pending_bytes.push_back(e);
    end
  endtask

  task automatic add_raw(logic [7:0] b, logic eos);
    src_byte_t e;
    e.b = b; e.eos = eos;
    pending_bytes.push_back(e);
  endtask

  // transfer seen at the rising edge, used by the driver at the next falling edge
  always @(posedge clk) took <= rst_n && push && !full;

  // driver: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (took) void'(pending_bytes.pop_front());
    if (!rst_n) push <= 1'b0;
    else if (gap_left > 0) begin
      gap_left <= gap_left - 1; push <= 1'b0;
    end else if (pending_bytes.size() == 0) begin
      push <= 1'b0;
    end else begin
      in_source_byte <= pending_bytes[0].b; in_end_of_source <= pending_bytes[0].eos;
      push <= 1'b1;
      if (burst_left > 0) burst_left <= burst_left - 1;
      else begin
        burst_left <= $urandom_range(30, 1);
        gap_left <= ($urandom_range(2, 0) == 0) ? $urandom_range(4, 1) : 0;
      end
    end
  end

  // receiver stall pattern
  logic [7:0] stall_pat = 8'hFF;
  always @(negedge clk) begin
    if (!rst_n) pop <= 1'b0;
    else begin
      if ($urandom_range(40, 0) == 0) stall_pat <= $urandom;
      pop <= !hold_off && (stall_pat[cycles % 8] || stall_pat == 8'h00);
    end
  end

  // monitor: prediction on accepted bytes, check on accepted tokens
  token_t got;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && push && !full) predict_tokens(in_source_byte, in_end_of_source);
    if (rst_n && pop && !empty) begin
      got.kind = out_token_kind; got.first = out_lexeme_first;
      got.fin = out_lexeme_final; got.last = out_run_last;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected token %p", got);
      end else begin
        if (expected_tokens[0] !== got) begin
          mismatches++;
          if (mismatches <= 10)
            $display("token mismatch: exp %p got %p", expected_tokens[0], got);
        end
        void'(expected_tokens.pop_front());
      end
    end
    if (cycles > Limit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  string frags[] = '{"abc_9 ", "12", "3.45", "7.", "x", "(* c *)", "// note\n", "==",
    "=>", ">>=", "<<=", "..=", "..", ".", "->", "&=", "|", "^=", "!=", "+", "%=",
    "*", "/=", "~", ":", ";", ",", "{}[]()", "\t", "\r\n", "(*)*)", "@", " "};

  initial begin
    logic [7:0] b;
    int n;
    scanner_reset();
    // directed sources
    add_raw(8'hEF, 0); add_raw(8'hBB, 0); add_raw(8'hBF, 0); add_text("a1 ", 1);
    add_raw(8'hEF, 0); add_text("x", 1);
    add_raw(8'hEF, 0); add_raw(8'hBB, 0); add_text("9.z0", 1);
    add_text("( ..= >>= <<= => ->", 1);
    add_text("12.", 1);
    add_text("(* open", 1);
    add_text("// tail", 1);
    add_raw(8'hFF, 0); add_raw(8'h80, 0); add_raw(8'h00, 0); add_raw(8'hAA, 0);
    add_raw(8'h55, 1);
    add_raw(8'h00, 1);
    add_raw(8'hEF, 1);
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    // random sources, mostly well-formed fragments
    n = 0;
    while (n < 100) begin
      if ($urandom_range(9, 0) == 0) begin
        b = $urandom; add_raw(b, $urandom_range(7, 0) == 0); n++;
      end else begin
        add_text(frags[$urandom_range(frags.size() - 1, 0)],
                 $urandom_range(9, 0) == 0);
        n += 3;
      end
      if (n > 60 && n < 70) begin
        hold_off = 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      while (pending_bytes.size() > 20) @(posedge clk);
    end
    add_raw(8'h00, 1);
    while (pending_bytes.size() > 0 || push) @(posedge clk);
    while (expected_tokens.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

/* filelist.f */
src/stok_pkg.sv
src/stok_front.sv
src/stok_queue.sv
src/stok_back.sv
src/source_tokenizer.sv
dv/tb_source_tokenizer.sv
